// File: rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg: shared types and codes for the message slot FIFO
// Word layouts of both channels, request and status codes, and the command
// and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int LIMIT_W = 7;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_PUSH_REJ  = 2'd1;
  localparam logic [1:0] ST_POP_DATA  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic [LIMIT_W-1:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_run;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic latch_pop;
    logic emit_empty;
    logic emit_blank;
    logic emit_byte;
    logic free_slot;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic queue_empty;
    logic run_empty;
    logic run_last;
  } dp_status_t;

endpackage

// File: rtl/msf_ram.sv
// ----------------------------------------------------------------------------
// msf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/msf_datapath.sv
// ----------------------------------------------------------------------------
// msf_datapath: slot storage, ring pointers and output register
// Holds the byte and length RAMs, the head, tail and fill bookkeeping, the
// pop run counter and the registered output word.
// ----------------------------------------------------------------------------
module msf_datapath import msf_pkg::*; #(
  parameter int SLOTS          = 16,
  parameter int BYTES_PER_SLOT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   req,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output out_item_t  rsp
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int OFF_W  = $clog2(BYTES_PER_SLOT + 1);
  localparam int DEPTH  = SLOTS * BYTES_PER_SLOT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(BYTES_PER_SLOT);

  logic [SLOT_W-1:0]  head;
  logic [SLOT_W-1:0]  tail;
  logic [CNT_W-1:0]   used;
  logic [OFF_W-1:0]   woff;
  logic               drop;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] cur;

  logic               full;
  logic               over;
  logic               drop_now;
  logic               store;
  logic               commit;
  logic               push_last;
  logic               load;
  logic [OFF_W-1:0]   woff_inc;
  logic [OFF_W-1:0]   rd_off;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_byte;
  logic [OFF_W-1:0]   len_q;
  logic [LIMIT_W-1:0] len_ext;
  logic [LIMIT_W-1:0] run_len;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    slot_base = ADDR_W'(s) * SLOT_SPAN;
  endfunction

  // A message is dropped once the ring is full or it outgrows its slot.
  assign full      = (used == CNT_W'(SLOTS));
  assign over      = (woff >= OFF_W'(BYTES_PER_SLOT));
  assign drop_now  = drop | full | over;
  assign store     = cmd.push & ~drop_now;
  assign push_last = cmd.push & req.last_byte;
  assign commit    = push_last & ~drop_now;
  assign woff_inc  = woff + OFF_W'(1);

  assign wr_addr = slot_base(tail) + ADDR_W'(woff);
  assign rd_off  = OFF_W'(cur + LIMIT_W'(cmd.advance));
  assign rd_addr = slot_base(head) + ADDR_W'(rd_off);

  msf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (wr_addr),
    .wr_data (req.data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_byte)
  );

  msf_ram #(
    .WIDTH (OFF_W),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (tail),
    .wr_data (woff_inc),
    .rd_addr (head),
    .rd_data (len_q)
  );

  assign len_ext = LIMIT_W'(len_q);
  assign run_len = (len_ext < limit) ? len_ext : limit;

  assign st.out_free    = ~rsp_valid | ~rsp_stall;
  assign st.queue_empty = (used == '0);
  assign st.run_empty   = (run_len == '0);
  assign st.run_last    = ((cur + LIMIT_W'(1)) == run_len);

  assign load = cmd.emit_empty | cmd.emit_blank | cmd.emit_byte | push_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      used      <= '0;
      woff      <= '0;
      drop      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        head <= '0;
        tail <= '0;
        used <= '0;
        woff <= '0;
        drop <= 1'b0;
      end
      if (cmd.push) begin
        if (req.last_byte) begin
          woff <= '0;
          drop <= 1'b0;
          if (commit) begin
            tail <= next_slot(tail);
            used <= used + CNT_W'(1);
          end
        end else begin
          drop <= drop_now;
          if (store) begin
            woff <= woff_inc;
          end
        end
      end
      if (cmd.free_slot) begin
        head <= next_slot(head);
        used <= used - CNT_W'(1);
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_pop) begin
      limit <= req.read_limit;
      cur   <= '0;
    end else if (cmd.advance) begin
      cur <= cur + LIMIT_W'(1);
    end
    if (push_last) begin
      rsp.status     <= drop_now ? ST_PUSH_REJ : ST_PUSH_OK;
      rsp.out_byte   <= '0;
      rsp.has_byte   <= 1'b0;
      rsp.end_of_run <= 1'b1;
    end else if (cmd.emit_empty) begin
      rsp.status     <= ST_EMPTY;
      rsp.out_byte   <= '0;
      rsp.has_byte   <= 1'b0;
      rsp.end_of_run <= 1'b1;
    end else if (cmd.emit_blank) begin
      rsp.status     <= ST_POP_DATA;
      rsp.out_byte   <= '0;
      rsp.has_byte   <= 1'b0;
      rsp.end_of_run <= 1'b1;
    end else if (cmd.emit_byte) begin
      rsp.status     <= ST_POP_DATA;
      rsp.out_byte   <= rd_byte;
      rsp.has_byte   <= 1'b1;
      rsp.end_of_run <= st.run_last;
    end
  end

endmodule

// File: rtl/msf_ctrl.sv
// ----------------------------------------------------------------------------
// msf_ctrl: request sequencer
// Takes request words, and steps a pop through the length read and the byte
// run, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module msf_ctrl import msf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_POP_LEN  = 2'd1;
  localparam logic [1:0] S_POP_DATA = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  assign req_stall = ~((state == S_IDLE) & st.out_free);
  assign take      = req_valid & ~req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (req_type)
            REQ_PUSH:  cmd.push = 1'b1;
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_POP: begin
              if (st.queue_empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.latch_pop = 1'b1;
                state_next    = S_POP_LEN;
              end
            end
            default: ;
          endcase
        end
      end
      // The stored length is valid now; the first byte is being read.
      S_POP_LEN: begin
        if (!st.run_empty) begin
          state_next = S_POP_DATA;
        end else if (st.out_free) begin
          cmd.emit_blank = 1'b1;
          cmd.free_slot  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_POP_DATA: begin
        if (st.out_free) begin
          cmd.emit_byte = 1'b1;
          if (st.run_last) begin
            cmd.free_slot = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/message_slot_fifo_top.sv
// Push and pop move one byte word per cycle while the output is free. Push: the status
// word appears in the cycle after the last byte. Pop: registered length read, then byte
// read; the request side stalls until the run is issued. A pop on an empty queue is
// answered from the idle state. All words pass through one output register.
// Synchronous reset empties the queue and the output register; storage is not cleared.
// ----------------------------------------------------------------------------
// message_slot_fifo_top: FIFO of fixed-size message slots
// Messages are pushed a byte at a time into a ring of slots and popped as
// byte runs, oldest first.
// ----------------------------------------------------------------------------
module message_slot_fifo_top import msf_pkg::*; #(
  parameter int SLOTS          = 16,
  parameter int BYTES_PER_SLOT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  msf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  msf_datapath #(
    .SLOTS          (SLOTS),
    .BYTES_PER_SLOT (BYTES_PER_SLOT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// File: rtl/msf_checker.sv
// ----------------------------------------------------------------------------
// msf_checker: port-level checks for the message slot FIFO
// Watches both channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module msf_checker import msf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input in_item_t  req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input out_item_t rsp
);

  // A stalled response word must hold.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !rsp_valid)
    else $error("response word present straight after reset");

  // Only pop data words may carry a byte.
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_byte |-> rsp.status == ST_POP_DATA)
    else $error("byte carried by a non-data word");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_POP_DATA |-> rsp.end_of_run && !rsp.has_byte)
    else $error("status word not a single closing word");

  // A clear produces no response.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.req_type == REQ_CLEAR && !rsp_valid |=> !rsp_valid)
    else $error("clear produced a response word");

endmodule

bind message_slot_fifo_top msf_checker u_msf_checker (.*);

// File: tb/sv/message_slot_fifo_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_slot_fifo_top_test: self-checking bench for the message slot FIFO
// A directed script runs first: extremes, full slots, overlong messages, a
// full queue, clears and pops on an empty queue. Then comes a long hold on
// the result side, and finally random message traffic. Every result word is
// checked against an in-bench model of the slot ring.
// ----------------------------------------------------------------------------
module message_slot_fifo_top_test;
  import msf_pkg::*;

  localparam int SLOTS          = 16;
  localparam int BYTES_PER_SLOT = 64;
  localparam int RANDOM_ITEMS   = 40;
  localparam int CALM_FROM      = 30;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 20;
  localparam int STALL_LIMIT    = 3000;
  localparam int MAX_PRINTED    = 20;

  // Request code that the block leaves alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  message_slot_fifo_top #(
    .SLOTS          (SLOTS),
    .BYTES_PER_SLOT (BYTES_PER_SLOT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the slot ring.
  logic [7:0]  slot_bytes [SLOTS*BYTES_PER_SLOT];
  int unsigned slot_len [SLOTS];
  int unsigned oldest_idx = 0;
  int unsigned fill_idx = 0;
  int unsigned occupied = 0;
  int unsigned fill_pos = 0;
  bit          dropping = 1'b0;

  out_item_t pending_results [$];

  int errors = 0;
  int words_in = 0;
  int words_checked = 0;
  int n_kept = 0;
  int n_refused = 0;
  int n_bytes = 0;
  int n_empty = 0;
  int n_clears = 0;
  int sent = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int stall_left = 0;

  // One directed step: the word is repeated reps times with the data byte
  // counting up. The last flag goes on every repetition or only the final one.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
    logic [6:0] limit;
    logic [6:0] reps;
    logic       last_each;
    logic       typed;
    logic [1:0] status;
  } script_step_t;

  script_step_t script [0:22] = '{
    '{REQ_POP,    8'h00, 1'b0, 7'd64,  7'd1,  1'b0, 1'b1, ST_EMPTY},
    '{REQ_PUSH,   8'h00, 1'b0, 7'd0,   7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_PUSH,   8'hFF, 1'b1, 7'd0,   7'd1,  1'b0, 1'b1, ST_PUSH_OK},
    '{REQ_POP,    8'h00, 1'b0, 7'd64,  7'd1,  1'b0, 1'b0, ST_POP_DATA},
    '{REQ_PUSH,   8'hA5, 1'b1, 7'd63,  7'd1,  1'b0, 1'b1, ST_PUSH_OK},
    '{REQ_POP,    8'hFF, 1'b1, 7'd0,   7'd1,  1'b0, 1'b1, ST_POP_DATA},
    '{REQ_UNUSED, 8'h5A, 1'b1, 7'd127, 7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_PUSH,   8'h00, 1'b1, 7'd0,   7'd64, 1'b0, 1'b1, ST_PUSH_OK},
    '{REQ_POP,    8'h00, 1'b0, 7'd63,  7'd1,  1'b0, 1'b0, ST_POP_DATA},
    '{REQ_PUSH,   8'h80, 1'b1, 7'd0,   7'd65, 1'b0, 1'b1, ST_PUSH_REJ},
    '{REQ_PUSH,   8'h11, 1'b0, 7'd0,   7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_POP,    8'h00, 1'b0, 7'd64,  7'd1,  1'b0, 1'b1, ST_EMPTY},
    '{REQ_PUSH,   8'h22, 1'b1, 7'd0,   7'd1,  1'b0, 1'b1, ST_PUSH_OK},
    '{REQ_PUSH,   8'h33, 1'b0, 7'd0,   7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_CLEAR,  8'h00, 1'b0, 7'd0,   7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_POP,    8'h00, 1'b0, 7'd64,  7'd1,  1'b0, 1'b1, ST_EMPTY},
    '{REQ_PUSH,   8'h44, 1'b1, 7'd0,   7'd1,  1'b0, 1'b1, ST_PUSH_OK},
    '{REQ_PUSH,   8'h10, 1'b1, 7'd0,   7'd16, 1'b1, 1'b0, ST_PUSH_OK},
    '{REQ_PUSH,   8'h99, 1'b1, 7'd0,   7'd1,  1'b0, 1'b1, ST_PUSH_REJ},
    '{REQ_POP,    8'h00, 1'b0, 7'd1,   7'd1,  1'b0, 1'b0, ST_POP_DATA},
    '{REQ_POP,    8'h00, 1'b0, 7'd64,  7'd1,  1'b0, 1'b0, ST_POP_DATA},
    '{REQ_CLEAR,  8'hFF, 1'b1, 7'd127, 7'd1,  1'b0, 1'b0, ST_PUSH_OK},
    '{REQ_POP,    8'h00, 1'b0, 7'd5,   7'd1,  1'b0, 1'b1, ST_EMPTY}
  };

  // Works out the result words that one accepted request word causes,
  // appends them to pending_results and returns how many there were.
  function automatic int predict_results(in_item_t w);
    out_item_t   r;
    int unsigned span;
    int unsigned base;
    int          added;
    added = 0;
    r = '0;
    r.end_of_run = 1'b1;
    case (w.req_type)
      REQ_PUSH: begin
        if (occupied >= SLOTS || fill_pos >= BYTES_PER_SLOT) begin
          dropping = 1'b1;
        end else if (!dropping) begin
          slot_bytes[fill_idx*BYTES_PER_SLOT + fill_pos] = w.data_byte;
          fill_pos++;
        end
        if (w.last_byte) begin
          if (dropping) begin
            r.status = ST_PUSH_REJ;
            n_refused++;
          end else begin
            slot_len[fill_idx] = fill_pos;
            fill_idx = (fill_idx + 1) % SLOTS;
            occupied++;
            r.status = ST_PUSH_OK;
            n_kept++;
          end
          pending_results.push_back(r);
          added = 1;
          fill_pos = 0;
          dropping = 1'b0;
        end
      end
      REQ_POP: begin
        if (occupied == 0) begin
          r.status = ST_EMPTY;
          pending_results.push_back(r);
          added = 1;
          n_empty++;
        end else begin
          span = (slot_len[oldest_idx] < w.read_limit) ? slot_len[oldest_idx]
                                                        : w.read_limit;
          base = oldest_idx * BYTES_PER_SLOT;
          if (span == 0) begin
            r.status = ST_POP_DATA;
            pending_results.push_back(r);
            added = 1;
          end else begin
            for (int i = 0; i < span; i++) begin
              r.status     = ST_POP_DATA;
              r.out_byte   = slot_bytes[base + i];
              r.has_byte   = 1'b1;
              r.end_of_run = (i + 1 == span);
              pending_results.push_back(r);
            end
            added = span;
            n_bytes += span;
          end
          oldest_idx = (oldest_idx + 1) % SLOTS;
          occupied--;
        end
      end
      REQ_CLEAR: begin
        oldest_idx = 0;
        fill_idx = 0;
        occupied = 0;
        fill_pos = 0;
        dropping = 1'b0;
        n_clears++;
      end
      default: begin
      end
    endcase
    return added;
  endfunction

  task automatic report_error(string text);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, text);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result word %p with nothing expected", got));
    end else begin
      want = pending_results.pop_front();
      words_checked++;
      if (got.status !== want.status) begin
        report_error($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.out_byte !== want.out_byte) begin
        report_error($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      end
      if (got.has_byte !== want.has_byte) begin
        report_error($sformatf("has_byte %b, expected %b", got.has_byte, want.has_byte));
      end
      if (got.end_of_run !== want.end_of_run) begin
        report_error($sformatf("end_of_run %b, expected %b", got.end_of_run,
                               want.end_of_run));
      end
    end
  endtask

  // Result side: check accepted words, then decide the stall for the next
  // cycle. A requested long hold takes precedence over random bursts.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      check_result(rsp);
    end
    if (hold_requests != holds_done) begin
      holds_done++;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9);
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic offer(input in_item_t w, output int added);
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    added = predict_results(w);
    words_in++;
  endtask

  task automatic send_word(logic [1:0] op, logic [7:0] d, logic last, logic [6:0] lim);
    in_item_t w;
    int       added;
    w.req_type   = op;
    w.data_byte  = d;
    w.last_byte  = last;
    w.read_limit = lim;
    maybe_gap();
    offer(w, added);
    if (op != REQ_UNUSED) begin
      sent++;
    end
    if (sent >= CALM_FROM) begin
      calm = 1'b1;
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 7'd0;
    end else if (r < 25) begin
      return 7'd64;
    end
    return 7'($urandom_range(1, 64));
  endfunction

  initial begin : stimulus
    in_item_t w;
    int       added;
    int       len;
    int       choice;
    int       r;
    bit       paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        w.req_type   = script[i].op;
        w.data_byte  = script[i].data + 8'(k);
        w.last_byte  = (script[i].last_each || k == script[i].reps - 1) ?
                       script[i].last : 1'b0;
        w.read_limit = script[i].limit;
        maybe_gap();
        offer(w, added);
        if (script[i].typed && added == 1) begin
          pending_results[pending_results.size()-1] =
            out_item_t'{script[i].status, 8'h00, 1'b0, 1'b1};
        end
      end
    end
    drain();

    // Hold the result side while short messages and pops keep coming, so
    // that the output fills up and the request side gets stalled.
    hold_requests++;
    for (int k = 0; k < 10; k++) begin
      w = '{REQ_PUSH, 8'($urandom_range(0, 255)), 1'b1, 7'd0};
      offer(w, added);
    end
    for (int k = 0; k < 3; k++) begin
      w = '{REQ_POP, 8'h00, 1'b0, 7'd64};
      offer(w, added);
    end
    drain();

    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = $urandom_range(1, 6);
        end else if (r < 96) begin
          len = $urandom_range(7, 24);
        end else if (r < 98) begin
          len = BYTES_PER_SLOT;
        end else begin
          len = $urandom_range(BYTES_PER_SLOT + 1, BYTES_PER_SLOT + 2);
        end
        for (int b = 0; b < len; b++) begin
          // Now and then a pop cuts in, or a clear abandons the message.
          if ($urandom_range(0, 99) < 3) begin
            send_word(REQ_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      pick_limit());
          end
          if (b > 0 && $urandom_range(0, 99) < 2) begin
            send_word(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      7'($urandom_range(0, 64)));
            break;
          end
          send_word(REQ_PUSH, 8'($urandom_range(0, 255)), b == len - 1,
                    7'($urandom_range(0, 64)));
        end
      end else if (choice < 90) begin
        send_word(REQ_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  pick_limit());
      end else if (choice < 95) begin
        send_word(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 64)));
      end else begin
        send_word(REQ_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)));
      end
    end
    drain();

    $display("summary: %0d request words, %0d result words checked, %0d errors",
             words_in, words_checked, errors);
    $display("summary: messages kept %0d, refused %0d; bytes popped %0d;",
             n_kept, n_refused, n_bytes);
    $display("summary: empty pops %0d; %0d clears", n_empty, n_clears);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Ends the run if neither side moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/msf_pkg.sv
rtl/msf_ram.sv
rtl/msf_datapath.sv
rtl/msf_ctrl.sv
rtl/message_slot_fifo_top.sv
rtl/msf_checker.sv
tb/sv/message_slot_fifo_top_test.sv
